// ----- hdl/irpdl_pkg.sv -----
`default_nettype none

package irpdl_pkg;

   // Field widths fixed by the frame format.
   localparam int TIME_W     = 16;
   localparam int ADJ_W      = 10;
   localparam int COUNT_W    = 7;
   localparam int BIT_IDX_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_BYTES_DEFAULT = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

   // Register reset values.
   localparam logic [TIME_W-1:0] DETECT_TIME_RESET   = 16'd2000;
   localparam logic [TIME_W-1:0] STOP_TIME_RESET     = 16'd3360;
   localparam logic [TIME_W-1:0] BIT_THRESHOLD_RESET = 16'd805;
   localparam logic [TIME_W-1:0] FORMAT_LIMIT_RESET  = 16'd6500;
   localparam logic [ADJ_W-1:0]  SENSOR_ADJUST_RESET = 10'd105;

   // Item opcodes and result kinds.
   localparam logic OP_TICK      = 1'b0;
   localparam logic OP_START     = 1'b1;
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DETECT_TIME   = 3'd0,
      CSR_STOP_TIME     = 3'd1,
      CSR_BIT_THRESHOLD = 3'd2,
      CSR_FORMAT_LIMIT  = 3'd3,
      CSR_SENSOR_ADJUST = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DETECT = 3'd1,
      PH_LMARK  = 3'd2,
      PH_LSPACE = 3'd3,
      PH_BMARK  = 3'd4,
      PH_BSPACE = 3'd5
   } phase_type;

   typedef struct packed {
      logic op;
      logic ir_present;
   } item_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        byte_value;
      logic [COUNT_W-1:0] byte_count;
      logic [TIME_W-1:0] leader_mark;
      logic [TIME_W-1:0] leader_space;
      logic [TIME_W-1:0] mark_mid;
      logic [TIME_W-1:0] one_space_mid;
      logic [TIME_W-1:0] zero_space_mid;
      logic              long_format;
      logic              last;
   } result_type;

   // Timer increment that sticks at the maximum.
   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
      return (v == TIME_MAX) ? v : v + 16'd1;
   endfunction

   // Space length plus the sensor delay, capped at the maximum.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [ADJ_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {7'd0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   // Mark length minus the sensor delay, floored at zero.
   function automatic logic [TIME_W-1:0] floor_sub(input logic [TIME_W-1:0] a,
                                                   input logic [ADJ_W-1:0] b);
      logic [TIME_W-1:0] bw;
      bw = {6'd0, b};
      return (a > bw) ? a - bw : 16'd0;
   endfunction

   function automatic logic [TIME_W-1:0] midpoint(input logic [TIME_W-1:0] lo,
                                                  input logic [TIME_W-1:0] hi);
      logic [TIME_W:0] s;
      s = {1'b0, lo} + {1'b0, hi};
      return s[TIME_W:1];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/irpdl_req_if.sv -----
`default_nettype none

interface irpdl_req_if;
   logic valid;
   logic ready;
   logic op;
   logic ir_present;

   modport source (output valid, output op, output ir_present, input ready);
   modport sink (input valid, input op, input ir_present, output ready);
endinterface

`default_nettype wire

// ----- hdl/irpdl_rsp_if.sv -----
`default_nettype none

interface irpdl_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  byte_value;
   logic [6:0]  byte_count;
   logic [15:0] leader_mark;
   logic [15:0] leader_space;
   logic [15:0] mark_mid;
   logic [15:0] one_space_mid;
   logic [15:0] zero_space_mid;
   logic        long_format;
   logic        last;

   modport source (output valid, output kind, output byte_value, output byte_count,
                   output leader_mark, output leader_space, output mark_mid,
                   output one_space_mid, output zero_space_mid, output long_format,
                   output last, input ready);
   modport sink (input valid, input kind, input byte_value, input byte_count,
                 input leader_mark, input leader_space, input mark_mid,
                 input one_space_mid, input zero_space_mid, input long_format,
                 input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/irpdl_core.sv -----
`default_nettype none

module irpdl_core #(
   parameter int MAX_BYTES = irpdl_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [irpdl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [irpdl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                item_valid,
   input  irpdl_pkg::item_type                 item,
   output logic [1:0]                          res_count,
   output irpdl_pkg::result_type               res0,
   output irpdl_pkg::result_type               res1
);

   localparam int TW = irpdl_pkg::TIME_W;
   localparam int CW = irpdl_pkg::COUNT_W;
   localparam int BW = irpdl_pkg::BIT_IDX_W;

   // Configuration registers.
   logic [TW-1:0]                  detect_time_ff, stop_time_ff, bit_threshold_ff;
   logic [TW-1:0]                  format_limit_ff;
   logic [irpdl_pkg::ADJ_W-1:0]    sensor_adjust_ff;

   // Capture state.
   irpdl_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0] timer_ff, timer_in;
   logic [TW-1:0] leader_mark_ff, leader_mark_in, leader_space_ff, leader_space_in;
   logic [TW-1:0] mark_hi_ff, mark_hi_in, mark_lo_ff, mark_lo_in;
   logic [TW-1:0] one_hi_ff, one_hi_in, one_lo_ff, one_lo_in;
   logic [TW-1:0] zero_hi_ff, zero_hi_in, zero_lo_ff, zero_lo_in;
   logic [7:0]    shift_ff, shift_in;
   logic [BW-1:0] bit_idx_ff, bit_idx_in;
   logic [CW-1:0] bytes_ff, bytes_in;

   // Shared timing terms.
   logic [TW-1:0] timer_inc, space_now, mark_now;
   logic          detect_hit, stop_first, stop_cont, bit_one, byte_done, bytes_full;
   logic          emit_byte, emit_summary;
   irpdl_pkg::result_type byte_res, summary_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_time_ff   <= irpdl_pkg::DETECT_TIME_RESET;
         stop_time_ff     <= irpdl_pkg::STOP_TIME_RESET;
         bit_threshold_ff <= irpdl_pkg::BIT_THRESHOLD_RESET;
         format_limit_ff  <= irpdl_pkg::FORMAT_LIMIT_RESET;
         sensor_adjust_ff <= irpdl_pkg::SENSOR_ADJUST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            irpdl_pkg::CSR_DETECT_TIME:   detect_time_ff   <= csr_wdata;
            irpdl_pkg::CSR_STOP_TIME:     stop_time_ff     <= csr_wdata;
            irpdl_pkg::CSR_BIT_THRESHOLD: bit_threshold_ff <= csr_wdata;
            irpdl_pkg::CSR_FORMAT_LIMIT:  format_limit_ff  <= csr_wdata;
            irpdl_pkg::CSR_SENSOR_ADJUST:
               sensor_adjust_ff <= csr_wdata[irpdl_pkg::ADJ_W-1:0];
            default: ;
         endcase
      end
   end

   // Terms derived from the current timer and registers.
   always_comb begin
      timer_inc  = irpdl_pkg::sat_inc(timer_ff);
      space_now  = irpdl_pkg::sat_add(timer_ff, sensor_adjust_ff);
      mark_now   = irpdl_pkg::floor_sub(timer_ff, sensor_adjust_ff);
      detect_hit = (item.ir_present ? timer_inc : 16'd0) >= detect_time_ff;
      stop_first = irpdl_pkg::sat_add(16'd1, sensor_adjust_ff) > stop_time_ff;
      stop_cont  = irpdl_pkg::sat_add(timer_inc, sensor_adjust_ff) > stop_time_ff;
      bit_one    = space_now > bit_threshold_ff;
      byte_done  = &bit_idx_ff;
      bytes_full = (bytes_ff + CW'(1)) >= CW'(MAX_BYTES);
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (item_valid) begin
         if (item.op == irpdl_pkg::OP_START) begin
            phase_in = irpdl_pkg::PH_DETECT;
         end else begin
            unique case (phase_ff)
               irpdl_pkg::PH_DETECT: begin
                  if (detect_hit) phase_in = irpdl_pkg::PH_LMARK;
               end
               irpdl_pkg::PH_LMARK: begin
                  if (!item.ir_present) phase_in = irpdl_pkg::PH_LSPACE;
               end
               irpdl_pkg::PH_LSPACE: begin
                  if (item.ir_present) phase_in = irpdl_pkg::PH_BMARK;
               end
               irpdl_pkg::PH_BMARK: begin
                  if (!item.ir_present) begin
                     phase_in = stop_first ? irpdl_pkg::PH_IDLE : irpdl_pkg::PH_BSPACE;
                  end
               end
               irpdl_pkg::PH_BSPACE: begin
                  if (!item.ir_present) begin
                     if (stop_cont) phase_in = irpdl_pkg::PH_IDLE;
                  end else if (byte_done && bytes_full) begin
                     phase_in = irpdl_pkg::PH_IDLE;
                  end else begin
                     phase_in = irpdl_pkg::PH_BMARK;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Measurement datapath and result requests.
   always_comb begin
      timer_in        = timer_ff;
      leader_mark_in  = leader_mark_ff;
      leader_space_in = leader_space_ff;
      mark_hi_in      = mark_hi_ff;
      mark_lo_in      = mark_lo_ff;
      one_hi_in       = one_hi_ff;
      one_lo_in       = one_lo_ff;
      zero_hi_in      = zero_hi_ff;
      zero_lo_in      = zero_lo_ff;
      shift_in        = shift_ff;
      bit_idx_in      = bit_idx_ff;
      bytes_in        = bytes_ff;
      emit_byte       = 1'b0;
      emit_summary    = 1'b0;
      if (item_valid) begin
         if (item.op == irpdl_pkg::OP_START) begin
            timer_in        = '0;
            leader_mark_in  = '0;
            leader_space_in = '0;
            mark_hi_in      = '0;
            mark_lo_in      = irpdl_pkg::TIME_MAX;
            one_hi_in       = '0;
            one_lo_in       = irpdl_pkg::TIME_MAX;
            zero_hi_in      = '0;
            zero_lo_in      = irpdl_pkg::TIME_MAX;
            shift_in        = '0;
            bit_idx_in      = '0;
            bytes_in        = '0;
         end else begin
            case (phase_ff)
               irpdl_pkg::PH_DETECT: begin
                  timer_in = item.ir_present ? timer_inc : 16'd0;
               end
               irpdl_pkg::PH_LMARK: begin
                  if (item.ir_present) begin
                     timer_in = timer_inc;
                  end else begin
                     leader_mark_in = mark_now;
                     timer_in       = 16'd1;
                  end
               end
               irpdl_pkg::PH_LSPACE: begin
                  if (!item.ir_present) begin
                     timer_in = timer_inc;
                  end else begin
                     leader_space_in = space_now;
                     timer_in        = 16'd1;
                  end
               end
               irpdl_pkg::PH_BMARK: begin
                  if (item.ir_present) begin
                     timer_in = timer_inc;
                  end else begin
                     if (mark_now > mark_hi_ff) mark_hi_in = mark_now;
                     if (mark_now < mark_lo_ff) mark_lo_in = mark_now;
                     timer_in     = 16'd1;
                     emit_summary = stop_first;
                  end
               end
               irpdl_pkg::PH_BSPACE: begin
                  if (!item.ir_present) begin
                     timer_in     = timer_inc;
                     emit_summary = stop_cont;
                  end else begin
                     if (bit_one) begin
                        if (space_now > one_hi_ff) one_hi_in = space_now;
                        if (space_now < one_lo_ff) one_lo_in = space_now;
                     end else begin
                        if (space_now > zero_hi_ff) zero_hi_in = space_now;
                        if (space_now < zero_lo_ff) zero_lo_in = space_now;
                     end
                     shift_in   = {shift_ff[6:0], bit_one};
                     bit_idx_in = bit_idx_ff + BW'(1);
                     timer_in   = 16'd1;
                     if (byte_done) begin
                        emit_byte    = 1'b1;
                        bytes_in     = bytes_ff + CW'(1);
                        emit_summary = bytes_full;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Result records; the summary sees the state as this item leaves it.
   always_comb begin
      byte_res            = '0;
      byte_res.kind       = irpdl_pkg::KIND_BYTE;
      byte_res.byte_value = shift_in;

      summary_res                = '0;
      summary_res.kind           = irpdl_pkg::KIND_SUMMARY;
      summary_res.byte_count     = bytes_in;
      summary_res.leader_mark    = leader_mark_in;
      summary_res.leader_space   = leader_space_in;
      summary_res.mark_mid       = irpdl_pkg::midpoint(mark_lo_in, mark_hi_in);
      summary_res.one_space_mid  = irpdl_pkg::midpoint(one_lo_in, one_hi_in);
      summary_res.zero_space_mid = irpdl_pkg::midpoint(zero_lo_in, zero_hi_in);
      summary_res.long_format    = leader_mark_in < format_limit_ff;
      summary_res.last           = 1'b1;

      res0      = emit_byte ? byte_res : summary_res;
      res1      = summary_res;
      res_count = {1'b0, emit_byte} + {1'b0, emit_summary};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= irpdl_pkg::PH_IDLE;
         timer_ff        <= '0;
         leader_mark_ff  <= '0;
         leader_space_ff <= '0;
         mark_hi_ff      <= '0;
         mark_lo_ff      <= irpdl_pkg::TIME_MAX;
         one_hi_ff       <= '0;
         one_lo_ff       <= irpdl_pkg::TIME_MAX;
         zero_hi_ff      <= '0;
         zero_lo_ff      <= irpdl_pkg::TIME_MAX;
         shift_ff        <= '0;
         bit_idx_ff      <= '0;
         bytes_ff        <= '0;
      end else begin
         phase_ff        <= phase_in;
         timer_ff        <= timer_in;
         leader_mark_ff  <= leader_mark_in;
         leader_space_ff <= leader_space_in;
         mark_hi_ff      <= mark_hi_in;
         mark_lo_ff      <= mark_lo_in;
         one_hi_ff       <= one_hi_in;
         one_lo_ff       <= one_lo_in;
         zero_hi_ff      <= zero_hi_in;
         zero_lo_ff      <= zero_lo_in;
         shift_ff        <= shift_in;
         bit_idx_ff      <= bit_idx_in;
         bytes_ff        <= bytes_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/irpdl_out_fifo.sv -----
`default_nettype none

module irpdl_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  irpdl_pkg::result_type push0,
   input  irpdl_pkg::result_type push1,
   input  logic                  pop,
   output logic                  head_valid,
   output irpdl_pkg::result_type head,
   output logic                  room_for_two
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   irpdl_pkg::result_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   // Pointer and fill bookkeeping; up to two items enter per cycle.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + (PW+1)'(push_count) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wr_ptr_ff + PW'(1)] <= push1;
   end

   assign head_valid   = count_ff != '0;
   assign head         = mem_ff[rd_ptr_ff];
   assign room_for_two = count_ff <= (PW+1)'(DEPTH - 2);

endmodule

`default_nettype wire

// ----- hdl/ir_pulse_distance_learner_top.sv -----
`default_nettype none

// Pulse-distance IR frame learner. Each item is either a one-microsecond sensor
// sample or a start command, and a new item can be accepted on every clock while
// the output queue has room for two results: the item is registered, processed by
// the combinational capture logic, and its results (a data byte, a frame summary,
// or a byte followed by the summary when the byte buffer fills) enter a four-entry
// output queue. The first result is offered once the item has passed the input
// register and been written into the queue. Input ready only drops while the
// queue has fewer than two free entries, i.e. while the result side stalls.
// The user must write configuration registers through the csr_ port only when no
// capture results are outstanding; the block itself does not enforce it.
module ir_pulse_distance_learner_top #(
   parameter int MAX_BYTES = irpdl_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   irpdl_req_if.sink                        req_ch,
   irpdl_rsp_if.source                      rsp_ch,
   input  logic                             csr_we,
   input  logic [irpdl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irpdl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                  in_valid_ff;
   irpdl_pkg::item_type   in_item_ff;
   logic                  in_go;
   logic                  room_for_two;
   logic [1:0]            res_count;
   irpdl_pkg::result_type res0, res1, head;
   logic                  head_valid;

   // Input register: moves on when the queue can take two results.
   assign in_go        = in_valid_ff && room_for_two;
   assign req_ch.ready = !in_valid_ff || in_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.op         <= req_ch.op;
         in_item_ff.ir_present <= req_ch.ir_present;
      end
   end

   irpdl_core #(
      .MAX_BYTES (MAX_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (in_go),
      .item       (in_item_ff),
      .res_count  (res_count),
      .res0       (res0),
      .res1       (res1)
   );

   irpdl_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (res_count),
      .push0        (res0),
      .push1        (res1),
      .pop          (rsp_ch.valid && rsp_ch.ready),
      .head_valid   (head_valid),
      .head         (head),
      .room_for_two (room_for_two)
   );

   // Result channel straight from the queue head.
   assign rsp_ch.valid          = head_valid;
   assign rsp_ch.kind           = head.kind;
   assign rsp_ch.byte_value     = head.byte_value;
   assign rsp_ch.byte_count     = head.byte_count;
   assign rsp_ch.leader_mark    = head.leader_mark;
   assign rsp_ch.leader_space   = head.leader_space;
   assign rsp_ch.mark_mid       = head.mark_mid;
   assign rsp_ch.one_space_mid  = head.one_space_mid;
   assign rsp_ch.zero_space_mid = head.zero_space_mid;
   assign rsp_ch.long_format    = head.long_format;
   assign rsp_ch.last           = head.last;

endmodule

`default_nettype wire

// ----- test/ir_pulse_distance_learner_top_test.sv -----
`timescale 1ns / 100ps

module ir_pulse_distance_learner_top_test;

   localparam int  TW             = irpdl_pkg::TIME_W;
   localparam int  AW             = irpdl_pkg::ADJ_W;
   localparam int  CW             = irpdl_pkg::COUNT_W;
   localparam int  IW             = irpdl_pkg::CSR_IDX_W;
   localparam int  DW             = irpdl_pkg::CSR_DATA_W;
   localparam real HALF_PERIOD    = 5.0;
   localparam int  FRAME_BYTES    = irpdl_pkg::MAX_BYTES_DEFAULT;
   localparam int  MAX_PAUSE      = 19;
   localparam int  SETTLE_CYCLES  = 8;
   localparam int  QUIET_LIMIT    = 2000;
   localparam int  RANDOM_ITEMS   = 100;
   localparam int  RANDOM_RECORDS = 8;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   logic [IW-1:0] csr_index;
   logic [DW-1:0] csr_wdata;

   irpdl_req_if req_ch ();
   irpdl_rsp_if rsp_ch ();

   ir_pulse_distance_learner_top #(.MAX_BYTES(FRAME_BYTES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Shadow copy of the registers.
   logic [TW-1:0] cfg_detect, cfg_stop, cfg_threshold, cfg_format;
   logic [AW-1:0] cfg_adjust;

   // Shadow copy of the capture state.
   irpdl_pkg::phase_type lrn_phase;
   logic [TW-1:0]        run_len, lead_mark, lead_space;
   logic [TW-1:0]        mark_lo, mark_hi, one_lo, one_hi, zero_lo, zero_hi;
   logic [7:0]           shift_reg;
   logic [2:0]           bit_pos;
   logic [CW-1:0]        byte_total;

   // Decoded bytes and frame summaries still to come out of the block.
   irpdl_pkg::result_type frame_records [$];
   irpdl_pkg::result_type want, got;

   bit sender_pauses   = 1'b0;
   bit receiver_pauses = 1'b0;
   int rsp_hold        = 0;
   int error_count     = 0;
   int live_items      = 0;
   int predicted_records = 0;
   int quiet_cycles    = 0;

   // Timer step that sticks at the top of its range.
   function automatic logic [TW-1:0] step_up(input logic [TW-1:0] len);
      return (&len) ? len : len + 16'd1;
   endfunction

   // Space length corrected for the sensor delay.
   function automatic logic [TW-1:0] with_delay(input logic [TW-1:0] len);
      int unsigned total;
      total = 32'(len) + 32'(cfg_adjust);
      return (total > 32'd65535) ? irpdl_pkg::TIME_MAX : total[15:0];
   endfunction

   // Mark length corrected for the sensor delay.
   function automatic logic [TW-1:0] without_delay(input logic [TW-1:0] len);
      return (len > {6'd0, cfg_adjust}) ? len - {6'd0, cfg_adjust} : 16'd0;
   endfunction

   function automatic logic [TW-1:0] centre(input logic [TW-1:0] lo,
                                            input logic [TW-1:0] hi);
      int unsigned total;
      total = 32'(lo) + 32'(hi);
      return total[16:1];
   endfunction

   task automatic widen(input logic [TW-1:0] len, inout logic [TW-1:0] lo,
                        inout logic [TW-1:0] hi);
      if (len > hi) hi = len;
      if (len < lo) lo = len;
   endtask

   task automatic forget_frame();
      run_len = '0;
      lead_mark = '0;
      lead_space = '0;
      mark_hi = '0;
      mark_lo = irpdl_pkg::TIME_MAX;
      one_hi = '0;
      one_lo = irpdl_pkg::TIME_MAX;
      zero_hi = '0;
      zero_lo = irpdl_pkg::TIME_MAX;
      shift_reg = '0;
      bit_pos = '0;
      byte_total = '0;
   endtask

   task automatic learner_reset();
      cfg_detect = irpdl_pkg::DETECT_TIME_RESET;
      cfg_stop = irpdl_pkg::STOP_TIME_RESET;
      cfg_threshold = irpdl_pkg::BIT_THRESHOLD_RESET;
      cfg_format = irpdl_pkg::FORMAT_LIMIT_RESET;
      cfg_adjust = irpdl_pkg::SENSOR_ADJUST_RESET;
      lrn_phase = irpdl_pkg::PH_IDLE;
      forget_frame();
   endtask

   task automatic emit_summary();
      irpdl_pkg::result_type rec;
      rec = '0;
      rec.kind = irpdl_pkg::KIND_SUMMARY;
      rec.byte_count = byte_total;
      rec.leader_mark = lead_mark;
      rec.leader_space = lead_space;
      rec.mark_mid = centre(mark_lo, mark_hi);
      rec.one_space_mid = centre(one_lo, one_hi);
      rec.zero_space_mid = centre(zero_lo, zero_hi);
      rec.long_format = lead_mark < cfg_format;
      rec.last = 1'b1;
      frame_records.push_back(rec);
      predicted_records++;
      lrn_phase = irpdl_pkg::PH_IDLE;
   endtask

   task automatic emit_byte();
      irpdl_pkg::result_type rec;
      rec = '0;
      rec.kind = irpdl_pkg::KIND_BYTE;
      rec.byte_value = shift_reg;
      frame_records.push_back(rec);
      predicted_records++;
   endtask

   // Advance the shadow capture state by one accepted item.
   task automatic learn_sample(input logic op_v, input logic ir_v);
      logic [TW-1:0] space_len;
      logic          one_bit;
      if (op_v == irpdl_pkg::OP_START) begin
         forget_frame();
         lrn_phase = irpdl_pkg::PH_DETECT;
         return;
      end
      case (lrn_phase)
         irpdl_pkg::PH_DETECT: begin
            run_len = ir_v ? step_up(run_len) : 16'd0;
            if (run_len >= cfg_detect) lrn_phase = irpdl_pkg::PH_LMARK;
         end
         irpdl_pkg::PH_LMARK: begin
            if (ir_v) begin
               run_len = step_up(run_len);
            end else begin
               lead_mark = without_delay(run_len);
               run_len = 16'd1;
               lrn_phase = irpdl_pkg::PH_LSPACE;
            end
         end
         irpdl_pkg::PH_LSPACE: begin
            if (!ir_v) begin
               run_len = step_up(run_len);
            end else begin
               lead_space = with_delay(run_len);
               run_len = 16'd1;
               lrn_phase = irpdl_pkg::PH_BMARK;
            end
         end
         irpdl_pkg::PH_BMARK: begin
            if (ir_v) begin
               run_len = step_up(run_len);
            end else begin
               widen(without_delay(run_len), mark_lo, mark_hi);
               run_len = 16'd1;
               lrn_phase = irpdl_pkg::PH_BSPACE;
               if (with_delay(run_len) > cfg_stop) emit_summary();
            end
         end
         irpdl_pkg::PH_BSPACE: begin
            if (!ir_v) begin
               run_len = step_up(run_len);
               if (with_delay(run_len) > cfg_stop) emit_summary();
            end else begin
               space_len = with_delay(run_len);
               one_bit = space_len > cfg_threshold;
               if (one_bit) widen(space_len, one_lo, one_hi);
               else widen(space_len, zero_lo, zero_hi);
               shift_reg = {shift_reg[6:0], one_bit};
               bit_pos = bit_pos + 3'd1;
               run_len = 16'd1;
               lrn_phase = irpdl_pkg::PH_BMARK;
               if (bit_pos == 3'd0) begin
                  emit_byte();
                  byte_total = byte_total + 7'd1;
                  if (byte_total >= CW'(FRAME_BYTES)) emit_summary();
               end
            end
         end
         default: ;
      endcase
   endtask

   // Offer one item after a random pause and wait until the block takes it.
   task automatic send_item(input logic op_v, input logic ir_v);
      int pause;
      pause = sender_pauses ? $urandom_range(MAX_PAUSE, 0) : 0;
      if (pause > 0) begin
         req_ch.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op_v;
      req_ch.ir_present <= ir_v;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      if (op_v == irpdl_pkg::OP_START || lrn_phase != irpdl_pkg::PH_IDLE) live_items++;
      learn_sample(op_v, ir_v);
   endtask

   task automatic hold_level(input logic level, input int count);
      repeat (count) send_item(irpdl_pkg::OP_TICK, level);
   endtask

   // Runs of alternating sensor level, the first run at the given level.
   task automatic send_pulses(input int lens[$], input logic first_level);
      logic level;
      level = first_level;
      foreach (lens[i]) begin
         hold_level(level, lens[i]);
         level = ~level;
      end
   endtask

   // Hold the space after the last bit until the frame times out or the limit is reached.
   task automatic close_frame(input int limit);
      int count;
      count = 0;
      while ((lrn_phase == irpdl_pkg::PH_BMARK || lrn_phase == irpdl_pkg::PH_BSPACE) &&
             count < limit) begin
         send_item(irpdl_pkg::OP_TICK, 1'b0);
         count++;
      end
   endtask

   // Let every predicted result drain and the pipeline empty.
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (frame_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_register(input irpdl_pkg::csr_index_type idx,
                               input logic [DW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_registers(input logic [TW-1:0] detect_v,
                                    input logic [TW-1:0] stop_v,
                                    input logic [TW-1:0] thresh_v,
                                    input logic [TW-1:0] format_v,
                                    input logic [AW-1:0] adjust_v);
      put_register(irpdl_pkg::CSR_DETECT_TIME, detect_v);
      put_register(irpdl_pkg::CSR_STOP_TIME, stop_v);
      put_register(irpdl_pkg::CSR_BIT_THRESHOLD, thresh_v);
      put_register(irpdl_pkg::CSR_FORMAT_LIMIT, format_v);
      put_register(irpdl_pkg::CSR_SENSOR_ADJUST, {6'd0, adjust_v});
      csr_we <= 1'b0;
      cfg_detect = detect_v;
      cfg_stop = stop_v;
      cfg_threshold = thresh_v;
      cfg_format = format_v;
      cfg_adjust = adjust_v;
   endtask

   // Reset timings apart from a short detect time: samples before any start
   // are ignored, and a frame of short zero bits fills the byte buffer.
   task automatic test_reset_timings();
      sender_pauses = 1'b1;
      receiver_pauses = 1'b1;
      send_pulses('{3, 2}, 1'b1);
      quiesce();
      put_register(irpdl_pkg::CSR_DETECT_TIME, DW'(4));
      csr_we <= 1'b0;
      cfg_detect = TW'(4);
      send_item(irpdl_pkg::OP_START, 1'b0);
      send_pulses('{6, 3}, 1'b1);
      repeat (FRAME_BYTES * 8) send_pulses('{1, $urandom_range(2, 1)}, 1'b1);
      hold_level(1'b1, 2);
   endtask

   // Every register at zero, then a zero threshold with a short stop.
   task automatic test_low_extremes();
      quiesce();
      program_registers(16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
      sender_pauses = 1'b1;
      receiver_pauses = 1'b1;
      // Detection passes at once and the first bit space ends the frame.
      send_item(irpdl_pkg::OP_START, 1'b1);
      send_pulses('{2, 1, 1}, 1'b0);
      quiesce();
      program_registers(16'd0, 16'd4, 16'd0, irpdl_pkg::TIME_MAX, 10'd0);
      send_item(irpdl_pkg::OP_START, 1'b0);
      send_pulses('{3, 2, 2, 1, 1, 3, 1, 4, 1}, 1'b1);
      close_frame(64);
   endtask

   task automatic test_threshold_edges();
      quiesce();
      program_registers(16'd3, 16'd20, 16'd10, 16'd9, 10'd2);
      sender_pauses = 1'b1;
      receiver_pauses = 1'b1;
      send_item(irpdl_pkg::OP_START, 1'b1);
      // A short mark broken by a space restarts the detection count.
      send_pulses('{2, 1, 5, 3}, 1'b1);
      // One byte: spaces at and just above the threshold, one space exactly at
      // the stop length, and some marks shorter than the adjustment.
      send_pulses('{1, 8, 4, 9, 2, 18, 3, 1, 1, 8, 2, 9, 6, 1, 1, 18}, 1'b1);
      // Three more bits that the stop throws away.
      send_pulses('{2, 9, 1, 8, 1, 9, 1}, 1'b1);
      close_frame(64);
      // A start in the middle of a frame drops it without a result.
      send_item(irpdl_pkg::OP_START, 1'b0);
      send_pulses('{4, 2, 1, 9}, 1'b1);
      send_item(irpdl_pkg::OP_START, 1'b1);
      send_pulses('{3, 1, 1}, 1'b1);
      close_frame(64);
   endtask

   // Largest sensor delay and format limit: marks floor at zero, spaces sit
   // just around a high threshold, and the stop falls one tick past the
   // longest space.
   task automatic test_top_of_range();
      quiesce();
      program_registers(16'd0, 16'd1030, 16'd1025, irpdl_pkg::TIME_MAX, 10'h3FF);
      sender_pauses = 1'b1;
      receiver_pauses = 1'b1;
      send_item(irpdl_pkg::OP_START, 1'b1);
      send_pulses('{2, 1}, 1'b1);
      send_pulses('{1, 1, 2, 2, 1, 3, 3, 7, 1, 2, 1, 4, 2, 3, 1, 1}, 1'b1);
      hold_level(1'b1, 2);
      close_frame(64);
   endtask

   // A well-formed frame with random content, sometimes cut short by a start.
   task automatic send_random_frame(input bit may_cut);
      int bits, cut_at, space_top, lead;
      sender_pauses = $urandom_range(3, 0) != 0;
      receiver_pauses = $urandom_range(3, 0) != 0;
      bits = $urandom_range(8, 0);
      cut_at = (may_cut && $urandom_range(7, 0) == 0) ? $urandom_range(bits, 0) : -1;
      space_top = int'(cfg_stop) - int'(cfg_adjust);
      lead = int'(cfg_detect) + $urandom_range(6, 1);
      if ($urandom_range(3, 0) == 0) begin
         repeat ($urandom_range(3, 1)) send_item(irpdl_pkg::OP_TICK, 1'($urandom_range(1, 0)));
      end
      send_item(irpdl_pkg::OP_START, 1'($urandom_range(1, 0)));
      if ($urandom_range(2, 0) == 0) begin
         send_pulses('{$urandom_range(3, 1), $urandom_range(2, 1)}, 1'b1);
      end
      send_pulses('{lead, $urandom_range(12, 1)}, 1'b1);
      for (int i = 0; i < bits; i++) begin
         if (i == cut_at) begin
            send_item(irpdl_pkg::OP_START, 1'($urandom_range(1, 0)));
            return;
         end
         send_pulses('{$urandom_range(4, 1), $urandom_range(space_top, 1)}, 1'b1);
      end
      hold_level(1'b1, $urandom_range(4, 1));
      close_frame(64);
   endtask

   // Rounds of random short timings, four frames each.
   task automatic test_random_frames();
      int items_from, records_from;
      logic [AW-1:0] adj;
      logic [TW-1:0] thr, stp;
      items_from = live_items;
      records_from = predicted_records;
      while (live_items - items_from < RANDOM_ITEMS ||
             predicted_records - records_from < RANDOM_RECORDS) begin
         adj = AW'($urandom_range(4, 0));
         thr = TW'(adj) + TW'($urandom_range(8, 1));
         stp = thr + TW'($urandom_range(8, 1));
         quiesce();
         program_registers(TW'($urandom_range(6, 0)), stp, thr,
                           TW'($urandom_range(16, 0)), adj);
         for (int f = 0; f < 4; f++) send_random_frame(f != 3);
      end
   endtask

   task automatic check_field(input string field, input logic [TW-1:0] want_v,
                              input logic [TW-1:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
         error_count++;
      end
   endtask

   // Take each result item once the drawn stall has run out and compare it
   // with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind = rsp_ch.kind;
            got.byte_value = rsp_ch.byte_value;
            got.byte_count = rsp_ch.byte_count;
            got.leader_mark = rsp_ch.leader_mark;
            got.leader_space = rsp_ch.leader_space;
            got.mark_mid = rsp_ch.mark_mid;
            got.one_space_mid = rsp_ch.one_space_mid;
            got.zero_space_mid = rsp_ch.zero_space_mid;
            got.long_format = rsp_ch.long_format;
            got.last = rsp_ch.last;
            if (frame_records.size() == 0) begin
               $display("%0t: unexpected result item, expected none, got kind %0d byte %0d",
                        $time, got.kind, got.byte_value);
               error_count++;
            end else begin
               want = frame_records.pop_front();
               check_field("kind", TW'(want.kind), TW'(got.kind));
               check_field("byte_value", TW'(want.byte_value), TW'(got.byte_value));
               check_field("byte_count", TW'(want.byte_count), TW'(got.byte_count));
               check_field("leader_mark", want.leader_mark, got.leader_mark);
               check_field("leader_space", want.leader_space, got.leader_space);
               check_field("mark_mid", want.mark_mid, got.mark_mid);
               check_field("one_space_mid", want.one_space_mid, got.one_space_mid);
               check_field("zero_space_mid", want.zero_space_mid, got.zero_space_mid);
               check_field("long_format", TW'(want.long_format), TW'(got.long_format));
               check_field("last", TW'(want.last), TW'(got.last));
            end
            rsp_hold = receiver_pauses ? $urandom_range(MAX_PAUSE, 0) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= irpdl_pkg::CSR_DETECT_TIME;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.op <= irpdl_pkg::OP_TICK;
      req_ch.ir_present <= 1'b0;
      learner_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_timings();
      test_low_extremes();
      test_threshold_edges();
      test_top_of_range();
      test_random_frames();
      quiesce();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/irpdl_pkg.sv
hdl/irpdl_req_if.sv
hdl/irpdl_rsp_if.sv
hdl/irpdl_core.sv
hdl/irpdl_out_fifo.sv
hdl/ir_pulse_distance_learner_top.sv
test/ir_pulse_distance_learner_top_test.sv
